[design/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros shared by the rate accumulator modules.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising clock edge outside reset.
`define SRA_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Checked on every rising clock edge, reset included.
`define SRA_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[design/sra_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sra_pkg
// Types, constants and saturating fixed-point helpers of the rate accumulator.
// ----------------------------------------------------------------------------
package sra_pkg;

	localparam int DATA_W                = 64;
	localparam int FRACTION_BITS_DEFAULT = 32;

	typedef logic signed [DATA_W-1:0] word_t;

	localparam word_t WORD_MAX = {1'b0, {(DATA_W-1){1'b1}}};
	localparam word_t WORD_MIN = {1'b1, {(DATA_W-1){1'b0}}};

	typedef enum logic {
		OP_MUL = 1'b0,
		OP_DIV = 1'b1
	} op_t;

	typedef struct packed {
		logic  start;
		op_t   op;
		word_t a;
		word_t b;
	} unit_req_t;

	typedef struct packed {
		logic  done;
		word_t res;
	} unit_rsp_t;

	function automatic word_t sat_add(word_t a, word_t b);
		word_t s;
		s = a + b;
		if ((a[DATA_W-1] == b[DATA_W-1]) && (s[DATA_W-1] != a[DATA_W-1]))
			return a[DATA_W-1] ? WORD_MIN : WORD_MAX;
		return s;
	endfunction

	function automatic word_t sat_sub(word_t a, word_t b);
		word_t s;
		s = a - b;
		if ((a[DATA_W-1] != b[DATA_W-1]) && (s[DATA_W-1] != a[DATA_W-1]))
			return a[DATA_W-1] ? WORD_MIN : WORD_MAX;
		return s;
	endfunction

	function automatic word_t sat_neg(word_t a);
		return (a == WORD_MIN) ? WORD_MAX : -a;
	endfunction

	function automatic logic [DATA_W-1:0] mag(word_t a);
		return a[DATA_W-1] ? (DATA_W'(0) - DATA_W'(a)) : DATA_W'(a);
	endfunction

	function automatic word_t pack_sat(logic neg, logic hi, logic [DATA_W-1:0] lo);
		if (hi)
			return neg ? WORD_MIN : WORD_MAX;
		if (lo[DATA_W-1])
			return neg ? WORD_MIN : WORD_MAX;
		return neg ? -word_t'(lo) : word_t'(lo);
	endfunction

endpackage

[design/sra_ifs.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sra_ifs
// Request and result channels of the rate accumulator.
// ----------------------------------------------------------------------------
interface sra_req_if;
	logic               valid;
	logic               ready;
	logic               mode;
	logic signed [63:0] position;
	logic signed [63:0] velocity;
	logic signed [63:0] density;
	logic signed [63:0] energy;
	logic        [62:0] smoothing_length;
	logic               last;

	modport source (output valid, mode, position, velocity, density, energy,
		smoothing_length, last, input ready);
	modport sink (input valid, mode, position, velocity, density, energy,
		smoothing_length, last, output ready);
endinterface

interface sra_rsp_if;
	logic               valid;
	logic               ready;
	logic signed [63:0] acceleration;
	logic signed [63:0] density_rate;
	logic signed [63:0] energy_rate;

	modport source (output valid, acceleration, density_rate, energy_rate, input ready);
	modport sink (input valid, acceleration, density_rate, energy_rate, output ready);
endinterface

[design/sra_muldiv.sv]
`timescale 1ns / 1ps
`include "assert_macros.svh"
// ----------------------------------------------------------------------------
// sra_muldiv
// Shared multi-cycle fixed-point multiplier and restoring divider.
// ----------------------------------------------------------------------------
module sra_muldiv import sra_pkg::*; #(
	parameter int FRACTION_BITS = FRACTION_BITS_DEFAULT
) (
	input  logic      clk,
	input  logic      arst_n,
	input  unit_req_t req,
	output unit_rsp_t rsp
);

	localparam int QW = DATA_W + FRACTION_BITS;
	localparam int CW = $clog2(QW + 1);
	localparam int AW = 2 * DATA_W;

	typedef enum logic [4:0] {
		U_IDLE  = 5'b00001,
		U_MUL   = 5'b00010,
		U_MPACK = 5'b00100,
		U_DIV   = 5'b01000,
		U_DRND  = 5'b10000
	} ustate_t;

	ustate_t           state_q;
	logic [CW-1:0]     cnt_q;
	logic              neg_q;
	logic [DATA_W-1:0] x_q;
	logic [DATA_W-1:0] y_q;
	logic [AW-1:0]     acc_q;
	logic [QW-1:0]     nq_q;
	logic [DATA_W-1:0] rem_q;
	logic              done_q;
	word_t             res_q;

	logic [31:0]       x_part;
	logic [31:0]       y_part;
	logic [63:0]       pp;
	logic [1:0]        sh;
	logic [AW-1:0]     acc_sh;
	logic [DATA_W:0]   r2;
	logic              ge;
	logic              rnd;
	logic [QW:0]       qsum;

	always_comb begin
		x_part = x_q[32*cnt_q[1] +: 32];
		y_part = y_q[32*cnt_q[0] +: 32];
		pp     = 64'(x_part) * 64'(y_part);
		sh     = 2'(cnt_q[1]) + 2'(cnt_q[0]);
		acc_sh = acc_q >> FRACTION_BITS;
		r2     = {rem_q, nq_q[QW-1]};
		ge     = r2 >= {1'b0, y_q};
		rnd    = rem_q >= (y_q - rem_q);
		qsum   = {1'b0, nq_q} + (QW+1)'(rnd);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= U_IDLE;
			cnt_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				U_IDLE: begin
					if (req.start) begin
						cnt_q <= '0;
						if (req.op == OP_MUL)
							state_q <= U_MUL;
						else if (req.b != '0)
							state_q <= U_DIV;
						else
							done_q <= 1'b1;
					end
				end
				U_MUL: begin
					cnt_q <= cnt_q + CW'(1);
					if (cnt_q == CW'(3))
						state_q <= U_MPACK;
				end
				U_MPACK: begin
					done_q  <= 1'b1;
					state_q <= U_IDLE;
				end
				U_DIV: begin
					cnt_q <= cnt_q + CW'(1);
					if (cnt_q == CW'(QW - 1))
						state_q <= U_DRND;
				end
				U_DRND: begin
					done_q  <= 1'b1;
					state_q <= U_IDLE;
				end
				default: state_q <= U_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			U_IDLE: begin
				if (req.start) begin
					neg_q <= req.a[DATA_W-1] ^ req.b[DATA_W-1];
					x_q   <= mag(req.a);
					y_q   <= mag(req.b);
					acc_q <= AW'(1) << (FRACTION_BITS - 1);
					nq_q  <= QW'(mag(req.a)) << FRACTION_BITS;
					rem_q <= '0;
					res_q <= req.a[DATA_W-1] ? WORD_MIN : WORD_MAX;
				end
			end
			U_MUL: begin
				acc_q <= acc_q + (AW'(pp) << {sh, 5'd0});
			end
			U_MPACK: begin
				res_q <= pack_sat(neg_q, |acc_sh[AW-1:DATA_W], acc_sh[DATA_W-1:0]);
			end
			U_DIV: begin
				rem_q <= ge ? DATA_W'(r2 - {1'b0, y_q}) : r2[DATA_W-1:0];
				nq_q  <= {nq_q[QW-2:0], ge};
			end
			U_DRND: begin
				res_q <= pack_sat(neg_q, |qsum[QW:DATA_W], qsum[DATA_W-1:0]);
			end
			default: ;
		endcase
	end

	assign rsp = '{done: done_q, res: res_q};

	`SRA_ASSERT(a_start_when_idle, req.start |-> (state_q == U_IDLE), "start while busy")
	`SRA_ASSERT(a_done_pulse, rsp.done |=> !rsp.done, "done held for two cycles")
	`SRA_ASSERT(a_mpack_after_mul, (state_q == U_MPACK) |-> $past(state_q == U_MUL),
		"product packed without accumulation")

endmodule

[design/sph_rate_accumulator.sv]
// A target request is loaded straight from idle; a neighbor request runs its
// operations one after another on the shared multiply/divide unit (up to five
// divisions of 64+FRACTION_BITS steps, up to nine 4-step multiplies).
// Only one neighbor request is handled at a time; ready is low until it finishes.
// A result still waiting on the output delays only the final multiply of the next group.
// Reset (arst_n low) clears the target, the three sums and all control state.
`timescale 1ns / 1ps
`include "assert_macros.svh"
// ----------------------------------------------------------------------------
// sph_rate_accumulator
// Accumulates 1D cubic-spline force, density and energy rates of one target.
// ----------------------------------------------------------------------------
module sph_rate_accumulator import sra_pkg::*; #(
	parameter int FRACTION_BITS = FRACTION_BITS_DEFAULT
) (
	input  logic      clk,
	input  logic      arst_n,
	sra_req_if.sink   req,
	sra_rsp_if.source rsp
);

	localparam word_t ONE          = word_t'(64'd1 << FRACTION_BITS);
	localparam word_t TWO          = word_t'(64'd2 << FRACTION_BITS);
	localparam word_t HALF         = word_t'(64'd1 << (FRACTION_BITS - 1));
	localparam word_t THREE_HALVES = word_t'(64'd3 << (FRACTION_BITS - 1));
	localparam word_t TWO_THIRDS   = word_t'(((64'd2 << FRACTION_BITS) + 64'd1) / 64'd3);

	typedef enum logic [14:0] {
		S_IDLE    = 15'h0001,
		S_QT_DIV  = 15'h0002,
		S_QT_MUL  = 15'h0004,
		S_QN_DIV  = 15'h0008,
		S_QN_MUL  = 15'h0010,
		S_U_DIV   = 15'h0020,
		S_K_A     = 15'h0040,
		S_K_B     = 15'h0080,
		S_G_DIV1  = 15'h0100,
		S_G_DIV2  = 15'h0200,
		S_P_FORCE = 15'h0400,
		S_P_DENS  = 15'h0800,
		S_P_SV    = 15'h1000,
		S_P_ENER  = 15'h2000,
		S_OUT_MUL = 15'h4000
	} state_t;

	state_t    state_q;
	logic      issued_q;
	logic      out_valid_q;
	unit_req_t unit_req;
	unit_rsp_t unit_rsp;

	word_t tp_q, tv_q, tdn_q, te_q, th_q;
	word_t fsum_q, dsum_q, esum_q;
	word_t npos_q, nvel_q, nden_q, nene_q;
	logic  nlast_q;
	word_t qt_q, s_q, dv_q, u_q, t_q, g_q;
	logic  neg_q, near_q;
	word_t acc_q, dr_q, er_q;
	word_t sep;

	sra_muldiv #(
		.FRACTION_BITS(FRACTION_BITS)
	) u_muldiv (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (unit_req),
		.rsp    (unit_rsp)
	);

	assign sep = sat_sub(tp_q, npos_q);

	always_comb begin
		unit_req.start = !issued_q && (state_q != S_IDLE) &&
			!((state_q == S_OUT_MUL) && out_valid_q);
		unit_req.op    = OP_MUL;
		unit_req.a     = '0;
		unit_req.b     = '0;
		unique case (state_q)
			S_QT_DIV: begin
				unit_req.op = OP_DIV;
				unit_req.a  = te_q;
				unit_req.b  = tdn_q;
			end
			S_QT_MUL, S_QN_MUL: begin
				unit_req.a = TWO_THIRDS;
				unit_req.b = t_q;
			end
			S_QN_DIV: begin
				unit_req.op = OP_DIV;
				unit_req.a  = nene_q;
				unit_req.b  = nden_q;
			end
			S_U_DIV: begin
				unit_req.op = OP_DIV;
				unit_req.a  = t_q;
				unit_req.b  = th_q;
			end
			S_K_A: begin
				unit_req.a = near_q ? THREE_HALVES : t_q;
				unit_req.b = near_q ? u_q : t_q;
			end
			S_K_B: begin
				unit_req.a = near_q ? u_q : HALF;
				unit_req.b = t_q;
			end
			S_G_DIV1, S_G_DIV2: begin
				unit_req.op = OP_DIV;
				unit_req.a  = g_q;
				unit_req.b  = th_q;
			end
			S_P_FORCE: begin
				unit_req.a = s_q;
				unit_req.b = g_q;
			end
			S_P_DENS: begin
				unit_req.a = dv_q;
				unit_req.b = g_q;
			end
			S_P_SV: begin
				unit_req.a = s_q;
				unit_req.b = dv_q;
			end
			S_P_ENER: begin
				unit_req.a = t_q;
				unit_req.b = g_q;
			end
			S_OUT_MUL: begin
				unit_req.a = esum_q;
				unit_req.b = HALF;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			issued_q    <= 1'b0;
			out_valid_q <= 1'b0;
			tp_q        <= '0;
			tv_q        <= '0;
			tdn_q       <= '0;
			te_q        <= '0;
			th_q        <= '0;
			fsum_q      <= '0;
			dsum_q      <= '0;
			esum_q      <= '0;
		end else begin
			if (unit_req.start)
				issued_q <= 1'b1;
			else if (unit_rsp.done)
				issued_q <= 1'b0;
			if (rsp.valid && rsp.ready)
				out_valid_q <= 1'b0;
			else if ((state_q == S_OUT_MUL) && unit_rsp.done)
				out_valid_q <= 1'b1;
			unique case (state_q)
				S_IDLE: begin
					if (req.valid) begin
						if (!req.mode) begin
							tp_q   <= req.position;
							tv_q   <= req.velocity;
							tdn_q  <= req.density;
							te_q   <= req.energy;
							th_q   <= word_t'({1'b0, req.smoothing_length});
							fsum_q <= '0;
							dsum_q <= '0;
							esum_q <= '0;
						end else begin
							state_q <= S_QT_DIV;
						end
					end
				end
				S_P_FORCE: if (unit_rsp.done) begin
					fsum_q  <= sat_add(fsum_q, unit_rsp.res);
					state_q <= S_P_DENS;
				end
				S_P_DENS: if (unit_rsp.done) begin
					dsum_q  <= sat_add(dsum_q, unit_rsp.res);
					state_q <= S_P_SV;
				end
				S_P_ENER: if (unit_rsp.done) begin
					esum_q  <= sat_add(esum_q, unit_rsp.res);
					state_q <= nlast_q ? S_OUT_MUL : S_IDLE;
				end
				S_OUT_MUL: if (unit_rsp.done) begin
					fsum_q  <= '0;
					dsum_q  <= '0;
					esum_q  <= '0;
					state_q <= S_IDLE;
				end
				S_QT_DIV:  if (unit_rsp.done) state_q <= S_QT_MUL;
				S_QT_MUL:  if (unit_rsp.done) state_q <= S_QN_DIV;
				S_QN_DIV:  if (unit_rsp.done) state_q <= S_QN_MUL;
				S_QN_MUL:  if (unit_rsp.done) state_q <= S_U_DIV;
				S_U_DIV: begin
					if (unit_rsp.done) begin
						if (unit_rsp.res <= TWO)
							state_q <= S_K_A;
						else
							state_q <= S_P_FORCE;
					end
				end
				S_K_A:     if (unit_rsp.done) state_q <= S_K_B;
				S_K_B:     if (unit_rsp.done) state_q <= S_G_DIV1;
				S_G_DIV1:  if (unit_rsp.done) state_q <= S_G_DIV2;
				S_G_DIV2:  if (unit_rsp.done) state_q <= S_P_FORCE;
				S_P_SV:    if (unit_rsp.done) state_q <= S_P_ENER;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == S_IDLE) && req.valid && req.mode) begin
			npos_q  <= req.position;
			nvel_q  <= req.velocity;
			nden_q  <= req.density;
			nene_q  <= req.energy;
			nlast_q <= req.last;
		end
		if (unit_rsp.done) begin
			unique case (state_q)
				S_QT_DIV, S_QN_DIV, S_P_SV: t_q <= unit_rsp.res;
				S_QT_MUL: qt_q <= unit_rsp.res;
				S_QN_MUL: begin
					s_q   <= sat_add(unit_rsp.res, qt_q);
					dv_q  <= sat_sub(tv_q, nvel_q);
					neg_q <= sep[DATA_W-1];
					t_q   <= sep[DATA_W-1] ? sat_neg(sep) : sep;
				end
				S_U_DIV: begin
					u_q    <= unit_rsp.res;
					near_q <= unit_rsp.res <= ONE;
					t_q    <= sat_sub(TWO, unit_rsp.res);
					g_q    <= '0;
				end
				S_K_A: t_q <= near_q ? sat_sub(unit_rsp.res, TWO) : unit_rsp.res;
				S_K_B, S_G_DIV1: g_q <= unit_rsp.res;
				S_G_DIV2: g_q <= (near_q == neg_q) ? sat_neg(unit_rsp.res) : unit_rsp.res;
				S_OUT_MUL: begin
					acc_q <= sat_neg(fsum_q);
					dr_q  <= dsum_q;
					er_q  <= unit_rsp.res;
				end
				default: ;
			endcase
		end
	end

	assign req.ready        = (state_q == S_IDLE);
	assign rsp.valid        = out_valid_q;
	assign rsp.acceleration = acc_q;
	assign rsp.density_rate = dr_q;
	assign rsp.energy_rate  = er_q;

	`SRA_ASSERT(a_result_held, (rsp.valid && !rsp.ready) |=> (rsp.valid && $stable(rsp.energy_rate)), "waiting result changed")
	`SRA_ASSERT(a_single_issue, unit_req.start |=> !unit_req.start, "unit started twice")
	`SRA_ASSERT(a_result_source, $rose(rsp.valid) |-> $past(state_q == S_OUT_MUL),
		"result raised outside the final multiply")

endmodule
